// File: design/hpt_pkg.sv
// shared types, codes and width helpers for the homogeneous point transform
package hpt_pkg;

   localparam int ENTRY_W   = 32;
   localparam int NUM_REGS  = 8;
   localparam int CSR_IDX_W = 4;

   typedef enum logic [1:0] {
      MODE_PROJ   = 2'd0,
      MODE_AFFINE = 2'd1,
      MODE_DIR    = 2'd2
   } mode_type;

   // sixteen matrix entries, entry r*4+c
   typedef logic [15:0][ENTRY_W-1:0] matrix_type;

   // width of the exact row sum before the floor shift
   function automatic int sum_width(input int cw, input int f);
      return ((cw > f) ? cw : f) + 34;
   endfunction

endpackage

// File: design/homogeneous_point_transform.sv
// top level: matrix registers, transform and divide pipelines, saturating output stage
//
//  channel  dir  handshake            payload
//  req      in   req_valid/req_stall  req_type, req_in_x, req_in_y, req_in_z
//  rsp      out  rsp_valid/rsp_stall  rsp_out_x/y/z, rsp_was_divided, rsp_saturated
//  csr      in   csr_valid/csr_ready  csr_index, csr_data
//
// one word per cycle while rsp_stall is low; a word passes through the three multiply/sum stages,
// the divide prep and range check, one stage per quotient bit
// and the output register
// reset clears all valid bits and loads the identity matrix
// rsp_stall holds only the stages that carry a word, so bubbles close up behind it
module homogeneous_point_transform #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_type,
   input  logic [31:0]                     req_in_x,
   input  logic [31:0]                     req_in_y,
   input  logic [31:0]                     req_in_z,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [31:0]                     rsp_out_x,
   output logic [31:0]                     rsp_out_y,
   output logic [31:0]                     rsp_out_z,
   output logic                            rsp_was_divided,
   output logic                            rsp_saturated,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hpt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [63:0]                     csr_data
);
   import hpt_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int RW = sum_width(CW, F) - F;
   localparam logic [ENTRY_W-1:0] ONE_Q = ENTRY_W'(1) << F;
   localparam logic signed [RW-1:0] RMAX = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [RW-1:0] RMIN = {{(RW-CW+1){1'b1}}, {(CW-1){1'b0}}};
   localparam logic [CW:0] QMAX_P = {2'b00, {(CW-1){1'b1}}};
   localparam logic [CW:0] QMAX_N = {2'b01, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

   logic [63:0]   regs_ff [NUM_REGS];
   matrix_type    matrix;

   logic          xf_valid, xf_stall, xf_proj;
   logic [2:0][RW-1:0] xf_res;
   logic [RW-1:0] xf_w;

   logic          dv_valid, dv_stall, dv_div;
   logic [2:0][RW-1:0] dv_raw;
   logic [2:0]    dv_neg, dv_ovf;
   logic [2:0][CW:0] dv_q;

   logic signed [CW-1:0] val_in [3];
   logic [2:0]    sat_in;
   logic          out_en;

   logic          rsp_valid_ff, div_ff, sat_ff;
   logic [31:0]   x_ff, y_ff, z_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[0] <= {ONE_Q, 32'd0};
         regs_ff[1] <= '0;
         regs_ff[2] <= {32'd0, ONE_Q};
         regs_ff[3] <= '0;
         regs_ff[4] <= '0;
         regs_ff[5] <= {ONE_Q, 32'd0};
         regs_ff[6] <= '0;
         regs_ff[7] <= {32'd0, ONE_Q};
      end else if (csr_valid && csr_ready && (csr_index < CSR_IDX_W'(NUM_REGS))) begin
         regs_ff[csr_index[2:0]] <= csr_data;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            matrix[r*4+c] = c[0] ? regs_ff[r*2 + c/2][31:0] : regs_ff[r*2 + c/2][63:32];
         end
      end
   end

   hpt_xform #(.COORD_WIDTH(CW), .FRAC_BITS(F)) u_xform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_mode   (mode_type'(req_type)),
      .in_x      (req_in_x[CW-1:0]),
      .in_y      (req_in_y[CW-1:0]),
      .in_z      (req_in_z[CW-1:0]),
      .matrix    (matrix),
      .out_valid (xf_valid),
      .out_stall (xf_stall),
      .out_proj  (xf_proj),
      .out_res   (xf_res),
      .out_w     (xf_w)
   );

   hpt_div #(.COORD_WIDTH(CW), .FRAC_BITS(F)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (xf_valid),
      .in_stall  (xf_stall),
      .in_proj   (xf_proj),
      .in_res    (xf_res),
      .in_w      (xf_w),
      .out_valid (dv_valid),
      .out_stall (dv_stall),
      .out_div   (dv_div),
      .out_raw   (dv_raw),
      .out_neg   (dv_neg),
      .out_ovf   (dv_ovf),
      .out_q     (dv_q)
   );

   assign out_en   = !rsp_valid_ff || !rsp_stall;
   assign dv_stall = !out_en;

   // saturate
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (dv_div) begin
            if (dv_ovf[l] || (dv_neg[l] ? (dv_q[l] > QMAX_N) : (dv_q[l] > QMAX_P))) begin
               sat_in[l] = 1'b1;
               val_in[l] = dv_neg[l] ? MINV : MAXV;
            end else begin
               sat_in[l] = 1'b0;
               val_in[l] = dv_neg[l] ? -dv_q[l][CW-1:0] : dv_q[l][CW-1:0];
            end
         end else if ($signed(dv_raw[l]) > RMAX) begin
            sat_in[l] = 1'b1;
            val_in[l] = MAXV;
         end else if ($signed(dv_raw[l]) < RMIN) begin
            sat_in[l] = 1'b1;
            val_in[l] = MINV;
         end else begin
            sat_in[l] = 1'b0;
            val_in[l] = dv_raw[l][CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         x_ff   <= 32'(val_in[0]);
         y_ff   <= 32'(val_in[1]);
         z_ff   <= 32'(val_in[2]);
         div_ff <= dv_div;
         sat_ff <= |sat_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = x_ff;
   assign rsp_out_y       = y_ff;
   assign rsp_out_z       = z_ff;
   assign rsp_was_divided = div_ff;
   assign rsp_saturated   = sat_ff;

`ifndef SYNTHESIS
   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("output valid right after reset");
   a_reset_identity: assert property (@(posedge clock)
      (!reset && $past(reset)) |->
         (regs_ff[0] == {ONE_Q, 32'd0}) && (regs_ff[7] == {32'd0, ONE_Q}))
      else $error("matrix not identity after reset");
`endif

endmodule

// File: design/hpt_xform.sv
// matrix multiply stages: products, partial sums, final sum with floor shift
module hpt_xform #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  hpt_pkg::mode_type       in_mode,
   input  logic [COORD_WIDTH-1:0]  in_x,
   input  logic [COORD_WIDTH-1:0]  in_y,
   input  logic [COORD_WIDTH-1:0]  in_z,
   input  hpt_pkg::matrix_type     matrix,
   output logic                    out_valid,
   input  logic                    out_stall,
   output logic                    out_proj,
   output logic [2:0][hpt_pkg::sum_width(COORD_WIDTH, FRAC_BITS)-FRAC_BITS-1:0] out_res,
   output logic [hpt_pkg::sum_width(COORD_WIDTH, FRAC_BITS)-FRAC_BITS-1:0]      out_w
);
   import hpt_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int PW = ENTRY_W + CW;
   localparam int SW = sum_width(CW, F);
   localparam int RW = SW - F;

   logic [2:0] v_ff;
   logic [2:0] en;

   logic signed [CW-1:0]      vec [3];
   logic signed [PW-1:0]      p_ff [4][3];
   logic signed [ENTRY_W-1:0] t_ff [4];
   logic                      proj1_ff, addt1_ff, proj2_ff, proj3_ff;
   logic                      use_t [4];
   logic signed [SW-1:0]      a_ff [4];
   logic signed [SW-1:0]      b_ff [4];
   logic signed [SW-1:0]      sum_in [4];
   logic [RW-1:0]             res_ff [4];

   assign en[2]    = !v_ff[2] || !out_stall;
   assign en[1]    = !v_ff[1] || en[2];
   assign en[0]    = !v_ff[0] || en[1];
   assign in_stall = !en[0];

   assign vec[0] = in_x;
   assign vec[1] = in_y;
   assign vec[2] = in_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         if (en[1]) v_ff[1] <= v_ff[0];
         if (en[2]) v_ff[2] <= v_ff[1];
      end
   end

   // products
   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
               p_ff[r][c] <= $signed(matrix[r*4+c]) * vec[c];
            end
            t_ff[r] <= $signed(matrix[r*4+3]);
         end
         proj1_ff <= (in_mode == MODE_PROJ);
         addt1_ff <= (in_mode == MODE_PROJ) || (in_mode == MODE_AFFINE);
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         use_t[r] = addt1_ff || (r == 3);
      end
   end

   // partial sums
   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int r = 0; r < 4; r++) begin
            a_ff[r] <= SW'(p_ff[r][0]) + SW'(p_ff[r][1]);
            b_ff[r] <= SW'(p_ff[r][2]) + (use_t[r] ? (SW'(t_ff[r]) <<< F) : '0);
         end
         proj2_ff <= proj1_ff;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         sum_in[r] = a_ff[r] + b_ff[r];
      end
   end

   // final sum, floor to the coordinate format
   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int r = 0; r < 4; r++) begin
            res_ff[r] <= sum_in[r][SW-1:F];
         end
         proj3_ff <= proj2_ff;
      end
   end

   assign out_valid  = v_ff[2];
   assign out_proj   = proj3_ff;
   assign out_res[0] = res_ff[0];
   assign out_res[1] = res_ff[1];
   assign out_res[2] = res_ff[2];
   assign out_w      = res_ff[3];

endmodule

// File: design/hpt_div.sv
// perspective divide: sign and magnitude prep, range check, one quotient bit per stage
module hpt_div #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  logic                   in_proj,
   input  logic [2:0][hpt_pkg::sum_width(COORD_WIDTH, FRAC_BITS)-FRAC_BITS-1:0] in_res,
   input  logic [hpt_pkg::sum_width(COORD_WIDTH, FRAC_BITS)-FRAC_BITS-1:0]      in_w,
   output logic                   out_valid,
   input  logic                   out_stall,
   output logic                   out_div,
   output logic [2:0][hpt_pkg::sum_width(COORD_WIDTH, FRAC_BITS)-FRAC_BITS-1:0] out_raw,
   output logic [2:0]             out_neg,
   output logic [2:0]             out_ovf,
   output logic [2:0][COORD_WIDTH:0] out_q
);
   import hpt_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int RW = sum_width(CW, F) - F;
   localparam int NW = RW + F + CW + 2;
   localparam int NS = CW + 3;
   localparam logic [RW-1:0] ONE_W = RW'(1) << F;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   logic          div_ff [NS];
   logic [RW-1:0] raw_ff [NS][3];
   logic          neg_ff [NS][3];
   logic          ovf_ff [NS][3];
   logic [NW-1:0] rem_ff [NS][3];
   logic [RW-1:0] ud_ff  [NS];
   logic [CW:0]   q_ff   [NS][3];

   logic [RW-1:0] mag_in [3];
   logic [RW-1:0] wmag_in;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || !out_stall;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end
   assign in_stall = !en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) begin
            if (en[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         mag_in[l] = in_res[l][RW-1] ? RW'(-in_res[l]) : in_res[l];
      end
      wmag_in = in_w[RW-1] ? RW'(-in_w) : in_w;
   end

   // prep
   always_ff @(posedge clock) begin
      if (en[0]) begin
         div_ff[0] <= in_proj && (in_w != ONE_W) && (in_w != '0);
         ud_ff[0]  <= wmag_in;
         for (int l = 0; l < 3; l++) begin
            raw_ff[0][l] <= in_res[l];
            neg_ff[0][l] <= in_res[l][RW-1] ^ in_w[RW-1];
            ovf_ff[0][l] <= 1'b0;
            rem_ff[0][l] <= NW'(mag_in[l]) << F;
            q_ff[0][l]   <= '0;
         end
      end
   end

   // quotient out of range
   always_ff @(posedge clock) begin
      if (en[1]) begin
         div_ff[1] <= div_ff[0];
         ud_ff[1]  <= ud_ff[0];
         for (int l = 0; l < 3; l++) begin
            raw_ff[1][l] <= raw_ff[0][l];
            neg_ff[1][l] <= neg_ff[0][l];
            ovf_ff[1][l] <= rem_ff[0][l] >= (NW'(ud_ff[0]) << (CW + 1));
            rem_ff[1][l] <= rem_ff[0][l];
            q_ff[1][l]   <= q_ff[0][l];
         end
      end
   end

   // restoring division, msb first
   for (genvar j = 2; j < NS; j++) begin : g_bit
      localparam int K = CW - (j - 2);
      logic [NW-1:0] trial;
      logic          hit [3];

      assign trial = NW'(ud_ff[j-1]) << K;

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            hit[l] = rem_ff[j-1][l] >= trial;
         end
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            div_ff[j] <= div_ff[j-1];
            ud_ff[j]  <= ud_ff[j-1];
            for (int l = 0; l < 3; l++) begin
               raw_ff[j][l] <= raw_ff[j-1][l];
               neg_ff[j][l] <= neg_ff[j-1][l];
               ovf_ff[j][l] <= ovf_ff[j-1][l];
               rem_ff[j][l] <= hit[l] ? (rem_ff[j-1][l] - trial) : rem_ff[j-1][l];
               q_ff[j][l]   <= {q_ff[j-1][l][CW-1:0], hit[l]};
            end
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_div   = div_ff[NS-1];

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         out_raw[l] = raw_ff[NS-1][l];
         out_neg[l] = neg_ff[NS-1][l];
         out_ovf[l] = ovf_ff[NS-1][l];
         out_q[l]   = q_ff[NS-1][l];
      end
   end

endmodule

// File: verif/homogeneous_point_transform_test.sv
// self-checking bench for the homogeneous point transform: directed table, random words
module homogeneous_point_transform_test;
   timeunit 1ns;
   timeprecision 1ps;
   import hpt_pkg::*;

   localparam int FRAC = 16;
   localparam logic [1:0] SEL_SPARE = 2'd3;
   localparam int SETTLE = 45;
   localparam int WATCH_LIMIT = 3000;
   localparam int MAX_SHOWN = 10;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        divided;
      logic        clamped;
   } point_res_t;

   typedef struct {
      logic [1:0]  sel;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        typed;
      point_res_t  want;
   } table_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_stall;
   logic [1:0] req_type = '0;
   logic [31:0] req_in_x = '0, req_in_y = '0, req_in_z = '0;
   logic rsp_valid, rsp_stall = 1'b0;
   logic [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_was_divided, rsp_saturated;
   logic csr_valid = 1'b0, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   logic [63:0] matrix_regs [NUM_REGS];
   point_res_t  pending [$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   bit          quiet = 1'b0;
   int          stall_left = 0;

   homogeneous_point_transform u_top (.*);

   always #5 clock = ~clock;

   function automatic logic signed [127:0] entry_of(int r, int c);
      logic [63:0] w;
      w = matrix_regs[r * 2 + c / 2];
      return (c % 2 == 0) ? 128'($signed(w[63:32])) : 128'($signed(w[31:0]));
   endfunction

   function automatic logic signed [127:0] row_sum(int r, logic signed [127:0] v [3],
                                                   bit with_t);
      logic signed [127:0] acc;
      acc = 0;
      for (int c = 0; c < 3; c++) acc += entry_of(r, c) * v[c];
      acc = acc >>> FRAC;
      if (with_t) acc += entry_of(r, 3);
      return acc;
   endfunction

   function automatic logic signed [127:0] q_divide(logic signed [127:0] n,
                                                    logic signed [127:0] d);
      logic [127:0] un, ud, q, rem;
      bit neg;
      if (d == 0) return n;
      neg = (n < 0) != (d < 0);
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      q = un / ud;
      rem = un % ud;
      if (q > (128'd1 << 32)) q = 128'd1 << 32;
      for (int i = 0; i < FRAC; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= ud) begin
            rem -= ud;
            q[0] = 1'b1;
         end
      end
      return neg ? -$signed(q) : $signed(q);
   endfunction

   function automatic point_res_t predict_point(logic [1:0] sel, logic [31:0] x,
                                                logic [31:0] y, logic [31:0] z);
      logic signed [127:0] v [3];
      logic signed [127:0] res [3];
      logic signed [127:0] w;
      logic [31:0] o [3];
      point_res_t p;
      v[0] = $signed(x);
      v[1] = $signed(y);
      v[2] = $signed(z);
      p.divided = 1'b0;
      p.clamped = 1'b0;
      for (int i = 0; i < 3; i++) res[i] = row_sum(i, v, sel < 2);
      if (sel == MODE_PROJ) begin
         w = row_sum(3, v, 1'b1);
         if (w != (128'sd1 <<< FRAC) && w != 0) begin
            p.divided = 1'b1;
            for (int i = 0; i < 3; i++) res[i] = q_divide(res[i], w);
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (res[i] > 128'sh7FFFFFFF) begin
            res[i] = 128'sh7FFFFFFF;
            p.clamped = 1'b1;
         end
         if (res[i] < -128'sh80000000) begin
            res[i] = -128'sh80000000;
            p.clamped = 1'b1;
         end
         o[i] = res[i][31:0];
      end
      p.x = o[0];
      p.y = o[1];
      p.z = o[2];
      return p;
   endfunction

   // result side: random stall per word, checks against the oldest expectation
   always @(posedge clock) begin
      point_res_t want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("unexpected word x=%h y=%h z=%h", rsp_out_x, rsp_out_y, rsp_out_z);
            end else begin
               want = pending.pop_front();
               if (want != {rsp_out_x, rsp_out_y, rsp_out_z, rsp_was_divided, rsp_saturated})
               begin
                  mismatches++;
                  if (mismatches <= MAX_SHOWN)
                     $display("mismatch exp x=%h y=%h z=%h d=%b s=%b got x=%h y=%h z=%h d=%b s=%b",
                              want.x, want.y, want.z, want.divided, want.clamped,
                              rsp_out_x, rsp_out_y, rsp_out_z, rsp_was_divided, rsp_saturated);
               end
            end
            stall_left = quiet ? 0 : $urandom_range(0, 5);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_word(logic [1:0] sel, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            bit typed, point_res_t want);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_type <= sel;
      req_in_x <= x;
      req_in_y <= y;
      req_in_z <= z;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      pending.push_back(typed ? want : predict_point(sel, x, y, z));
   endtask

   task automatic write_reg(int idx, logic [63:0] value);
      csr_index <= idx[CSR_IDX_W-1:0];
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx < NUM_REGS) matrix_regs[idx] = value;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      wait (pending.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_entry(bit wide);
      return wide ? $urandom : ($urandom_range(0, 32'h3FFFF) - 32'h20000);
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 32'hFFFFF) - 32'h80000;
         2: return ($urandom_range(0, 1) == 1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return $urandom_range(0, 32'h7FFFF) - 32'h40000;
      endcase
   endfunction

   task automatic load_matrix(int style);
      logic [31:0] e [16];
      bit wide;
      int pick;
      wide = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < 16; i++) e[i] = rand_entry(wide);
      // bottom row: identity, zero or tiny w, else random
      pick = $urandom_range(0, 3);
      if (pick < 3) begin
         e[12] = 32'h0;
         e[13] = 32'h0;
         e[14] = 32'h0;
         e[15] = (pick == 0) ? 32'h10000 : ((pick == 1) ? 32'h0 : 32'h1);
      end
      for (int r = 0; r < NUM_REGS; r++) begin
         case (style)
            0: write_reg(r, 64'h0);
            1: write_reg(r, 64'h7FFFFFFF_7FFFFFFF);
            2: write_reg(r, 64'h80000000_80000000);
            3: write_reg(r, 64'hFFFFFFFF_FFFFFFFF);
            default: write_reg(r, {e[2 * r], e[2 * r + 1]});
         endcase
      end
      write_reg(NUM_REGS + $urandom_range(0, 7), {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   table_row_t stim [12];

   initial begin
      point_res_t none;
      logic [1:0] sel;
      logic [31:0] a, b, c;
      int pick;
      none = '0;
      matrix_regs[0] = 64'h00010000_00000000;
      matrix_regs[1] = 64'h0;
      matrix_regs[2] = 64'h00000000_00010000;
      matrix_regs[3] = 64'h0;
      matrix_regs[4] = 64'h0;
      matrix_regs[5] = 64'h00010000_00000000;
      matrix_regs[6] = 64'h0;
      matrix_regs[7] = 64'h00000000_00010000;
      // identity after reset: every mode passes the point through
      stim[0] = '{MODE_PROJ, 32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b1,
                  '{32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b0, 1'b0}};
      stim[1] = '{MODE_AFFINE, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1,
                  '{32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0}};
      stim[2] = '{MODE_DIR, 32'hFFFFFFFF, 32'h00010000, 32'h80000000, 1'b1,
                  '{32'hFFFFFFFF, 32'h00010000, 32'h80000000, 1'b0, 1'b0}};
      stim[3] = '{SEL_SPARE, 32'h12345678, 32'hEDCBA987, 32'h7FFFFFFF, 1'b1,
                  '{32'h12345678, 32'hEDCBA987, 32'h7FFFFFFF, 1'b0, 1'b0}};
      stim[4] = '{MODE_PROJ, 32'h0, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0}};
      stim[5] = '{MODE_PROJ, 32'h55555555, 32'hAAAAAAAA, 32'h00000001, 1'b0, none};
      stim[6] = '{MODE_AFFINE, 32'hAAAAAAAA, 32'h55555555, 32'h80000001, 1'b0, none};
      stim[7] = '{MODE_DIR, 32'h00008000, 32'hFFFF8000, 32'h00000001, 1'b0, none};
      stim[8] = '{SEL_SPARE, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0, none};
      stim[9] = '{MODE_PROJ, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, none};
      stim[10] = '{MODE_AFFINE, 32'h0, 32'hFFFFFFFF, 32'h00010000, 1'b0, none};
      stim[11] = '{MODE_DIR, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1'b0, none};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim[i])
         send_word(stim[i].sel, stim[i].x, stim[i].y, stim[i].z, stim[i].typed, stim[i].want);
      drain();

      // extremes first, then random matrices with identity, zero and tiny w rows
      for (int ph = 0; ph < 14; ph++) begin
         load_matrix(ph);
         quiet = (ph % 4 == 1);
         if (ph < 4) begin
            foreach (stim[i]) send_word(stim[i].sel, stim[i].x, stim[i].y, stim[i].z, 1'b0, none);
         end
         for (int n = 0; n < 130; n++) begin
            pick = $urandom_range(0, 5);
            sel = (pick > 3) ? MODE_PROJ : pick[1:0];
            a = rand_coord();
            b = rand_coord();
            c = rand_coord();
            send_word(sel, a, b, c, 1'b0, none);
         end
         drain();
      end
      quiet = 1'b0;

      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
